// File: design/kvrws_pkg.sv
// ----------------------------------------------------------------------------
// kvrws_pkg
// Constants, header word positions and helper functions for the key-value
// response word serializer.
// ----------------------------------------------------------------------------
package kvrws_pkg;

   localparam int VALUE_BYTES_MAX = 128;
   localparam int BUF_WORDS       = (VALUE_BYTES_MAX + 3) / 4;
   localparam int ADDR_W          = (BUF_WORDS > 1) ? $clog2(BUF_WORDS) : 1;
   localparam int MAX_WORDS       = 7 + BUF_WORDS;
   localparam int CNT_W           = $clog2(MAX_WORDS);

   localparam logic [7:0] MAGIC_RESPONSE = 8'd129;
   localparam logic [7:0] OPCODE_GET     = 8'd0;
   localparam logic [7:0] HEADER_BYTES   = 8'd24;
   localparam logic [7:0] EXTRAS_BYTES   = 8'd4;
   localparam logic [7:0] MISS_BYTES     = 8'd9;
   localparam logic [7:0] STATUS_MISS    = 8'd1;
   localparam logic [3:0] KEEP_ALL       = 4'd15;
   localparam logic [31:0] EXTRAS_WORD   = {8'd239, 8'd190, 8'd173, 8'd222};
   localparam logic [7:0] VLEN_MAX       = 8'(VALUE_BYTES_MAX);

   // output word positions within a packet
   localparam logic [CNT_W-1:0] WORD_MAGIC  = CNT_W'(0);
   localparam logic [CNT_W-1:0] WORD_STATUS = CNT_W'(1);
   localparam logic [CNT_W-1:0] WORD_BODY   = CNT_W'(2);
   localparam logic [CNT_W-1:0] WORD_OPAQUE = CNT_W'(3);
   localparam logic [CNT_W-1:0] WORD_CAS_HI = CNT_W'(4);
   localparam logic [CNT_W-1:0] WORD_CAS_LO = CNT_W'(5);
   localparam logic [CNT_W-1:0] WORD_EXTRAS = CNT_W'(6);
   localparam logic [CNT_W-1:0] WORD_VALUE  = CNT_W'(7);
   localparam logic [CNT_W-1:0] WORD_MISS_LAST = CNT_W'(8);

   // "Not found", four bytes a word, first byte in bits 7:0
   function automatic logic [31:0] miss_word(input logic [1:0] idx);
      logic [31:0] w;
      case (idx)
         2'd0:    w = {8'd32, 8'd116, 8'd111, 8'd78};
         2'd1:    w = {8'd110, 8'd117, 8'd111, 8'd102};
         2'd2:    w = {24'd0, 8'd100};
         default: w = 32'd0;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] keep_from_rem(input logic [7:0] rem);
      logic [3:0] k;
      case (rem)
         8'd0:    k = 4'b0000;
         8'd1:    k = 4'b0001;
         8'd2:    k = 4'b0011;
         8'd3:    k = 4'b0111;
         default: k = 4'b1111;
      endcase
      return k;
   endfunction

   function automatic logic [31:0] lane_mask(input logic [3:0] keep);
      return {{8{keep[3]}}, {8{keep[2]}}, {8{keep[1]}}, {8{keep[0]}}};
   endfunction

   function automatic logic [31:0] swap_bytes(input logic [31:0] v);
      return {v[7:0], v[15:8], v[23:16], v[31:24]};
   endfunction

endpackage

// File: design/kv_response_word_serializer_top.sv
// ----------------------------------------------------------------------------
// kv_response_word_serializer_top
// Frames binary key-value cache responses as a stream of 32-bit words.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken when start is high and busy is low.
//   req_mode = 0 writes req_word_bytes into value buffer word req_word_index;
//   busy stays low and nothing is sent.
//   req_mode = 1 sends one response packet. busy rises the next cycle and
//   one word leaves per cycle on the rsp_ ports, marked by rsp_valid:
//   6 header words, then for a GET hit the extras word and ceil(len/4)
//   value words (len held to VALUE_BYTES_MAX), for a GET miss three
//   "Not found" words, else nothing.
//   A packet is 6 to 7 + VALUE_BYTES_MAX/4 words. busy is high while those
//   words go out and falls after the word that carries rsp_last_word, so
//   the next transaction can be taken in the cycle after that word.
//   The word counter of the sequencer ends the packet; value words come
//   from the buffer memory through its single registered read port, which
//   is addressed one word ahead.
//   The receiver cannot stall: each word is valid for one cycle only.
//   Reset clears only the busy flag of the sequencer; the value buffer is
//   not cleared, so a hit must only cover words that were loaded.
// ----------------------------------------------------------------------------
module kv_response_word_serializer_top
   import kvrws_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_mode,
   input  logic [4:0]  req_word_index,
   input  logic [31:0] req_word_bytes,
   input  logic [7:0]  req_request_opcode,
   input  logic [31:0] req_request_opaque,
   input  logic        req_entry_found,
   input  logic [7:0]  req_value_length,
   output logic        rsp_valid,
   output logic [31:0] rsp_out_word,
   output logic [3:0]  rsp_byte_keep,
   output logic        rsp_last_word,
   output logic [7:0]  rsp_payload_length
);

   logic [31:0] value_mem [BUF_WORDS];
   logic [31:0] rd_data_ff;
   logic [ADDR_W-1:0] rd_addr;

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] last_ff, last_in;
   logic [7:0]       rem_ff, rem_in;
   logic [7:0]       opcode_ff, opcode_in;
   logic [31:0]      opaque_ff, opaque_in;
   logic             hit_ff, hit_in;
   logic             miss_ff, miss_in;
   logic [7:0]       body_ff, body_in;

   logic             accept, load_acc, resp_acc;
   logic             is_get;
   logic [7:0]       vlen_sat;
   logic [8:0]       vlen_round;
   logic [CNT_W-1:0] value_words;
   logic [CNT_W-1:0] miss_idx;
   logic             body_phase;
   logic [CNT_W-1:0] addr_full;

   assign accept   = start && !busy_ff;
   assign load_acc = accept && !req_mode;
   assign resp_acc = accept && req_mode;

   assign is_get      = (req_request_opcode == OPCODE_GET);
   assign vlen_sat    = (req_value_length > VLEN_MAX) ? VLEN_MAX : req_value_length;
   assign vlen_round  = 9'(vlen_sat) + 9'd3;
   assign value_words = CNT_W'(vlen_round >> 2);

   // value buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (load_acc && (32'(req_word_index) < 32'(BUF_WORDS))) begin
         value_mem[ADDR_W'(req_word_index)] <= req_word_bytes;
      end
   end

   // fetch one word ahead: the word read now goes out at the next count
   assign addr_full = cnt_ff - WORD_EXTRAS;
   assign rd_addr   = addr_full[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      rd_data_ff <= value_mem[rd_addr];
   end

   assign body_phase = hit_ff ? (cnt_ff >= WORD_VALUE) : (miss_ff && (cnt_ff >= WORD_EXTRAS));

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      last_in   = last_ff;
      rem_in    = rem_ff;
      opcode_in = opcode_ff;
      opaque_in = opaque_ff;
      hit_in    = hit_ff;
      miss_in   = miss_ff;
      body_in   = body_ff;
      if (resp_acc) begin
         busy_in   = 1'b1;
         cnt_in    = WORD_MAGIC;
         opcode_in = req_request_opcode;
         opaque_in = req_request_opaque;
         hit_in    = is_get && req_entry_found;
         miss_in   = is_get && !req_entry_found;
         if (is_get && req_entry_found) begin
            last_in = WORD_EXTRAS + value_words;
            rem_in  = vlen_sat;
            body_in = EXTRAS_BYTES + vlen_sat;
         end else if (is_get) begin
            last_in = WORD_MISS_LAST;
            rem_in  = MISS_BYTES;
            body_in = MISS_BYTES;
         end else begin
            last_in = WORD_CAS_LO;
            rem_in  = 8'd0;
            body_in = 8'd0;
         end
      end else if (busy_ff) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (body_phase) begin
            rem_in = rem_ff - 8'd4;
         end
         if (cnt_ff == last_ff) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff    <= cnt_in;
      last_ff   <= last_in;
      rem_ff    <= rem_in;
      opcode_ff <= opcode_in;
      opaque_ff <= opaque_in;
      hit_ff    <= hit_in;
      miss_ff   <= miss_in;
      body_ff   <= body_in;
   end

   assign miss_idx = cnt_ff - WORD_EXTRAS;

   always_comb begin
      rsp_byte_keep = KEEP_ALL;
      case (cnt_ff)
         WORD_MAGIC:  rsp_out_word = {16'd0, opcode_ff, MAGIC_RESPONSE};
         WORD_STATUS: rsp_out_word = {(miss_ff ? STATUS_MISS : 8'd0), 16'd0,
                                      (hit_ff ? EXTRAS_BYTES : 8'd0)};
         WORD_BODY:   rsp_out_word = {body_ff, 24'd0};
         WORD_OPAQUE: rsp_out_word = swap_bytes(opaque_ff);
         WORD_CAS_HI: rsp_out_word = 32'd0;
         WORD_CAS_LO: rsp_out_word = 32'd0;
         default: begin
            if (hit_ff && (cnt_ff == WORD_EXTRAS)) begin
               rsp_out_word = EXTRAS_WORD;
            end else begin
               // drop unkept lanes on a partial final word
               rsp_byte_keep = keep_from_rem(rem_ff);
               rsp_out_word  = (hit_ff ? rd_data_ff : miss_word(miss_idx[1:0]))
                               & lane_mask(keep_from_rem(rem_ff));
            end
         end
      endcase
   end

   assign busy               = busy_ff;
   assign rsp_valid          = busy_ff;
   assign rsp_last_word      = (cnt_ff == last_ff);
   assign rsp_payload_length = HEADER_BYTES + body_ff;

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_word |=> !rsp_valid)
      else $error("word stream continues after last word");

   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_word |=> rsp_valid)
      else $error("packet interrupted before last word");

   a_magic_first: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_mode |=> rsp_valid && (rsp_out_word[7:0] == MAGIC_RESPONSE))
      else $error("packet does not open with magic byte");

   a_partial_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_byte_keep != KEEP_ALL) |-> rsp_last_word && (rsp_byte_keep != 4'd0))
      else $error("partial keep on a word that is not last");

   a_plen_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_word |=> $stable(rsp_payload_length))
      else $error("payload length changed within a packet");

endmodule
